FILE: rtl/l1ms_pkg.sv
// l1ms_pkg: shared types and constants for the l1 medoid select block
// no dependencies; used by l1ms_cell and l1_medoid_select_top
package l1ms_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_W        = 32;
  localparam int TAG_W          = 16;
  localparam int SCORE_W        = 43;
  localparam int ADIFF_W        = COORD_W + 1;
  localparam int DSUM_W         = COORD_W + 2;
  localparam int DRAIN_W        = 2;

  // three absolute differences must settle through the cell pipeline before the token
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(3);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic        [TAG_W-1:0]   point_tag;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic [TAG_W-1:0]   best_tag;
    logic [SCORE_W-1:0] best_score;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t             pos;
    logic [TAG_W-1:0] tag;
  } stored_t;

  // control part of the minimum token that runs down the chain
  typedef struct packed {
    logic valid;
    logic have;
  } tok_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_CHAIN,
    ST_RESULT
  } state_t;

endpackage

FILE: rtl/l1ms_cell.sv
// l1ms_cell: one cell of the chain, holds one point and its running l1 sum
// depends on l1ms_pkg
module l1ms_cell #(
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = 8,
  parameter int CNT_W      = 9,
  parameter int SUM_W      = 42
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic [CNT_W-1:0]    n,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  l1ms_pkg::vec_t      wr_pos,
  input  logic                s_in_valid,
  input  l1ms_pkg::vec_t      s_in_pos,
  output logic                s_out_valid,
  output l1ms_pkg::vec_t      s_out_pos,
  input  l1ms_pkg::tok_ctl_t  tok_in_ctl,
  input  logic [SUM_W-1:0]    tok_in_sum,
  input  logic [IDX_W-1:0]    tok_in_idx,
  output l1ms_pkg::tok_ctl_t  tok_out_ctl,
  output logic [SUM_W-1:0]    tok_out_sum,
  output logic [IDX_W-1:0]    tok_out_idx
);

  l1ms_pkg::vec_t                   own;
  logic [l1ms_pkg::ADIFF_W-1:0]     ad_x, ad_y, ad_z;
  logic [l1ms_pkg::ADIFF_W-1:0]     s1_x, s1_y, s1_z;
  logic                             s1_valid;
  logic [l1ms_pkg::DSUM_W-1:0]      s2_sum;
  logic                             s2_valid;
  logic [SUM_W-1:0]                 acc;
  logic                             in_set;
  logic                             take;

  function automatic logic [l1ms_pkg::ADIFF_W-1:0] abs_diff(
    input logic signed [l1ms_pkg::COORD_W-1:0] a,
    input logic signed [l1ms_pkg::COORD_W-1:0] b
  );
    logic [l1ms_pkg::ADIFF_W-1:0] d;
    d = {a[l1ms_pkg::COORD_W-1], a} - {b[l1ms_pkg::COORD_W-1], b};
    return d[l1ms_pkg::ADIFF_W-1] ? (~d + 1'b1) : d;
  endfunction

  // own point, written while loading
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      own <= wr_pos;
    end
  end

  // stream passes to the neighbour every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s_out_valid <= 1'b0;
    end else begin
      s_out_valid <= s_in_valid;
    end
    s_out_pos <= s_in_pos;
  end

  assign ad_x = abs_diff(own.x, s_in_pos.x);
  assign ad_y = abs_diff(own.y, s_in_pos.y);
  assign ad_z = abs_diff(own.z, s_in_pos.z);

  // abs differences, then their sum, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= s_in_valid;
      s2_valid <= s1_valid;
    end
    s1_x   <= ad_x;
    s1_y   <= ad_y;
    s1_z   <= ad_z;
    s2_sum <= l1ms_pkg::DSUM_W'(s1_x) + l1ms_pkg::DSUM_W'(s1_y) + l1ms_pkg::DSUM_W'(s1_z);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + SUM_W'(s2_sum);
    end
  end

  // cell takes part only if it holds a point of this set; strict less keeps the earliest
  assign in_set = (n > CNT_W'(CELL_IDX));
  assign take   = in_set && (!tok_in_ctl.have || (acc < tok_in_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_ctl <= '0;
    end else begin
      tok_out_ctl.valid <= tok_in_ctl.valid;
      tok_out_ctl.have  <= tok_in_ctl.have || take;
    end
    if (take) begin
      tok_out_sum <= acc;
      tok_out_idx <= IDX_W'(CELL_IDX);
    end else begin
      tok_out_sum <= tok_in_sum;
      tok_out_idx <= tok_in_idx;
    end
  end

endmodule

FILE: rtl/l1_medoid_select_top.sv
// l1_medoid_select_top: l1 medoid selection over a loaded set of 3-d points
// depends on l1ms_pkg and l1ms_cell
//
//  channel   signals                 direction  transaction
//  input     start, busy, point      in         start high while busy low
//  result    done, result            out        done high for one cycle
//
// loading writes each accepted point into the store; busy stays low until a
// point marked last arrives. that point starts the pass: the store memory streams
// the n stored points down the row of MAX_POINTS cells, one a cycle, each cell
// summing its l1 distance to every point, then a minimum token walks the row.
// each cell pipeline has three stages: abs differences, their sum and the
// accumulator. busy drops in the cycle after done. reset (rst, synchronous)
// empties the set and clears the overflow flag; no clearing pass is needed. the
// receiver cannot stall: a result is on the ports for exactly one cycle.
module l1_medoid_select_top #(
  parameter int MAX_POINTS = l1ms_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  l1ms_pkg::point_t    point,
  output logic                done,
  output l1ms_pkg::result_t   result
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 34 + $clog2(MAX_POINTS);
  localparam int EXT_W = (SUM_W > l1ms_pkg::SCORE_W) ? SUM_W : l1ms_pkg::SCORE_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(MAX_POINTS - 1);
  localparam logic [EXT_W-1:0] SCORE_MAX = EXT_W'({l1ms_pkg::SCORE_W{1'b1}});

  l1ms_pkg::state_t   state, state_next;

  // point store, written while loading, read in stream order and by winner index
  l1ms_pkg::stored_t  mem [MAX_POINTS];
  l1ms_pkg::stored_t  rdata;
  logic [IDX_W-1:0]   rd_addr;

  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [IDX_W-1:0]   addr;
  logic [l1ms_pkg::DRAIN_W-1:0] drain_cnt;
  logic [SUM_W-1:0]   best_sum;
  logic               strm_valid;
  logic               accept;
  logic               room;
  logic               last_addr;
  logic               inject;
  logic [EXT_W-1:0]   sum_ext;
  l1ms_pkg::vec_t     wr_pos;

  // chain wiring, element k feeds cell k
  logic                  s_valid [MAX_POINTS+1];
  l1ms_pkg::vec_t        s_pos   [MAX_POINTS+1];
  l1ms_pkg::tok_ctl_t    t_ctl   [MAX_POINTS+1];
  logic [SUM_W-1:0]      t_sum   [MAX_POINTS+1];
  logic [IDX_W-1:0]      t_idx   [MAX_POINTS+1];

  assign accept    = start && !busy;
  assign room      = (count < CNT_W'(MAX_POINTS));
  assign last_addr = (CNT_W'(addr) == (count - 1'b1));
  assign wr_pos    = '{x: point.point_x, y: point.point_y, z: point.point_z};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      l1ms_pkg::ST_IDLE: begin
        if (accept && point.last_point) state_next = l1ms_pkg::ST_STREAM;
      end
      l1ms_pkg::ST_STREAM: begin
        if (last_addr) state_next = l1ms_pkg::ST_DRAIN;
      end
      l1ms_pkg::ST_DRAIN: begin
        if (drain_cnt == l1ms_pkg::DRAIN_LAST) state_next = l1ms_pkg::ST_CHAIN;
      end
      l1ms_pkg::ST_CHAIN: begin
        if (t_ctl[MAX_POINTS].valid) state_next = l1ms_pkg::ST_RESULT;
      end
      l1ms_pkg::ST_RESULT: begin
        state_next = l1ms_pkg::ST_IDLE;
      end
      default: begin
        state_next = l1ms_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    busy    = 1'b1;
    done    = 1'b0;
    inject  = 1'b0;
    rd_addr = addr;
    unique case (state)
      l1ms_pkg::ST_IDLE:   busy = 1'b0;
      l1ms_pkg::ST_STREAM: rd_addr = addr;
      l1ms_pkg::ST_DRAIN:  inject = (drain_cnt == l1ms_pkg::DRAIN_LAST);
      l1ms_pkg::ST_CHAIN:  rd_addr = t_idx[MAX_POINTS] & IDX_MASK;
      l1ms_pkg::ST_RESULT: done = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= l1ms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (state == l1ms_pkg::ST_RESULT) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (room) begin
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      drain_cnt  <= '0;
      strm_valid <= 1'b0;
    end else begin
      strm_valid <= (state == l1ms_pkg::ST_STREAM);
      if (state == l1ms_pkg::ST_STREAM) begin
        addr <= addr + 1'b1;
      end else begin
        addr <= '0;
      end
      if (state == l1ms_pkg::ST_DRAIN) begin
        drain_cnt <= drain_cnt + 1'b1;
      end else begin
        drain_cnt <= '0;
      end
    end
  end

  // store memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[count[IDX_W-1:0]] <= '{pos: wr_pos, tag: point.point_tag};
    end
    rdata <= mem[rd_addr];
  end

  // winner's score, captured as the token leaves the row
  always_ff @(posedge clk) begin
    if ((state == l1ms_pkg::ST_CHAIN) && t_ctl[MAX_POINTS].valid) begin
      best_sum <= t_sum[MAX_POINTS];
    end
  end

  // head of the chain
  assign s_valid[0] = strm_valid;
  assign s_pos[0]   = rdata.pos;
  assign t_ctl[0]   = '{valid: inject, have: 1'b0};
  assign t_sum[0]   = '0;
  assign t_idx[0]   = '0;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    l1ms_cell #(
      .CELL_IDX   (k),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .SUM_W      (SUM_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .clear       (state == l1ms_pkg::ST_IDLE),
      .n           (count),
      .wr_en       (accept && room),
      .wr_idx      (count[IDX_W-1:0]),
      .wr_pos      (wr_pos),
      .s_in_valid  (s_valid[k]),
      .s_in_pos    (s_pos[k]),
      .s_out_valid (s_valid[k+1]),
      .s_out_pos   (s_pos[k+1]),
      .tok_in_ctl  (t_ctl[k]),
      .tok_in_sum  (t_sum[k]),
      .tok_in_idx  (t_idx[k]),
      .tok_out_ctl (t_ctl[k+1]),
      .tok_out_sum (t_sum[k+1]),
      .tok_out_idx (t_idx[k+1])
    );
  end

  // score saturates at the width of the result field
  assign sum_ext = EXT_W'(best_sum);

  always_comb begin
    result.best_tag   = rdata.tag;
    result.best_score = (sum_ext > SCORE_MAX) ? {l1ms_pkg::SCORE_W{1'b1}}
                                              : sum_ext[l1ms_pkg::SCORE_W-1:0];
    result.overflow   = ovf;
  end

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for l1_medoid_select_top, the l1 medoid picker
// depends on l1ms_pkg for the point and result transaction types and sizes
// keeps its own copy of the point set and predicts each winner when a set closes
module tb_top;
  import l1ms_pkg::*;

  localparam int MAX_POINTS = MAX_POINTS_DEF;

  // DRAIN_CYCLES covers a set closing after its last point (stream, then the
  // token's walk along the row) plus slack; the stall limit is a multiple of it
  localparam int DRAIN_CYCLES = 2 * MAX_POINTS + 16;
  localparam int STALL_LIMIT  = 8 * DRAIN_CYCLES;

  localparam longint unsigned SCORE_CAP = (64'd1 << SCORE_W) - 64'd1;

  localparam logic signed [COORD_W-1:0] C_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN  = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_ONE  = 32'sh0001_0000;  // 1.0 in q16.16
  localparam logic signed [COORD_W-1:0] C_ODD  = 32'sh5555_5555;
  localparam logic signed [COORD_W-1:0] C_EVEN = 32'shAAAA_AAAA;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  point_t  point = '0;
  logic    done;
  result_t result;

  // shadow of the point store, filled as transactions are accepted
  vec_t                 set_pos [MAX_POINTS];
  logic [TAG_W-1:0]     set_tag [MAX_POINTS];
  int                   set_count   = 0;
  bit                   set_dropped = 1'b0;

  // winners still to come out of the block, oldest first
  result_t pending_winners [$];

  int points_sent    = 0;
  int points_dropped = 0;
  int sets_checked   = 0;
  int error_count    = 0;
  int stall_cycles   = 0;

  l1_medoid_select_top #(
    .MAX_POINTS(MAX_POINTS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .point  (point),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // distance along one axis, exact in 64 bits
  function automatic longint unsigned axis_gap(logic signed [COORD_W-1:0] a,
                                               logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  // take one accepted point into the shadow set; on the closing point pick the
  // point with the least summed l1 distance, earliest on a tie
  task automatic track_point(input point_t p);
    result_t         winner;
    longint unsigned dist_sum;
    longint unsigned best_sum;
    int              best_idx;
    if (set_count < MAX_POINTS) begin
      set_pos[set_count].x = p.point_x;
      set_pos[set_count].y = p.point_y;
      set_pos[set_count].z = p.point_z;
      set_tag[set_count]   = p.point_tag;
      set_count++;
    end else begin
      // store full: the point is lost but the set is flagged
      set_dropped = 1'b1;
      points_dropped++;
    end
    if (p.last_point) begin
      best_idx = 0;
      best_sum = 0;
      for (int i = 0; i < set_count; i++) begin
        dist_sum = 0;
        for (int j = 0; j < set_count; j++) begin
          dist_sum += axis_gap(set_pos[i].x, set_pos[j].x)
                    + axis_gap(set_pos[i].y, set_pos[j].y)
                    + axis_gap(set_pos[i].z, set_pos[j].z);
        end
        if (i == 0 || dist_sum < best_sum) begin
          best_sum = dist_sum;
          best_idx = i;
        end
      end
      if (best_sum > SCORE_CAP) best_sum = SCORE_CAP;
      winner.best_tag   = set_tag[best_idx];
      winner.best_score = best_sum[SCORE_W-1:0];
      winner.overflow   = set_dropped;
      pending_winners.insert(pending_winners.size(), winner);
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------------

  function automatic point_t make_point(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y,
                                        logic signed [COORD_W-1:0] z,
                                        logic [TAG_W-1:0] tag, logic last);
    point_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.point_tag  = tag;
    p.last_point = last;
    return p;
  endfunction

  // one input transaction: optional idle burst, then hold start until busy is
  // low at a rising edge. start stays high on return so back-to-back points
  // go in without an idle gap; the next call or an idle burst decides its level
  task automatic send_point(input point_t p, input bit gaps_allowed);
    if (gaps_allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    point <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    points_sent++;
    track_point(p);
  endtask

  // coordinate mix: tight cluster round the set centre (so the winner moves
  // about the set), anything at all, and both rails
  function automatic logic signed [COORD_W-1:0] pick_coord(
      logic signed [COORD_W-1:0] centre);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return centre + COORD_W'(int'($urandom_range(0, 8191)) - 4096);
    if (sel < 88) return $urandom;
    if (sel < 94) return C_MAX;
    return C_MIN;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a set of one point: score zero, its own tag back
  task automatic test_lone_point();
    send_point(make_point(C_MAX, C_MIN, '0, 16'hFFFF, 1'b1), 1'b1);
  endtask

  // two points at opposite corners score the same, so the first must win
  task automatic test_opposite_tie();
    send_point(make_point(C_MIN, C_MIN, C_MIN, 16'h0000, 1'b0), 1'b1);
    send_point(make_point(C_MAX, C_MAX, C_MAX, 16'hFFFF, 1'b1), 1'b1);
  endtask

  // rails, zero, plus and minus one lsb and alternating bit patterns
  task automatic test_coord_extremes();
    send_point(make_point(C_MAX,  C_MIN,  32'sd0,  16'h5555, 1'b0), 1'b1);
    send_point(make_point(C_MIN,  C_MAX,  -32'sd1, 16'hAAAA, 1'b0), 1'b1);
    send_point(make_point(32'sd1, -32'sd1, C_MAX,  16'h0000, 1'b0), 1'b1);
    send_point(make_point(C_ODD,  C_EVEN, C_MIN,   16'hFFFF, 1'b0), 1'b1);
    send_point(make_point(C_EVEN, C_ODD,  C_ODD,   16'h0001, 1'b0), 1'b1);
    send_point(make_point(32'sd0, 32'sd0, 32'sd0,  16'h8000, 1'b0), 1'b1);
    send_point(make_point(-32'sd1, 32'sd1, C_EVEN, 16'h7FFF, 1'b1), 1'b1);
  endtask

  // points on the x axis; the median arrives last and has to win
  task automatic test_late_winner();
    send_point(make_point(32'sd0,     '0, '0, 16'd10, 1'b0), 1'b1);
    send_point(make_point(1000*C_ONE, '0, '0, 16'd11, 1'b0), 1'b1);
    send_point(make_point(3000*C_ONE, '0, '0, 16'd12, 1'b0), 1'b1);
    send_point(make_point(4000*C_ONE, '0, '0, 16'd13, 1'b0), 1'b1);
    send_point(make_point(2000*C_ONE, '0, '0, 16'd14, 1'b1), 1'b1);
  endtask

  // two identical central points tie; the earlier of the pair wins
  task automatic test_duplicate_tie();
    send_point(make_point(-5*C_ONE, C_ONE, '0, 16'd20, 1'b0), 1'b1);
    send_point(make_point(32'sd0,   C_ONE, '0, 16'd21, 1'b0), 1'b1);
    send_point(make_point(5*C_ONE,  C_ONE, '0, 16'd22, 1'b0), 1'b1);
    send_point(make_point(32'sd0,   C_ONE, '0, 16'd23, 1'b1), 1'b1);
  endtask

  // an exactly full store closed by its last slot, then an over-full set of
  // rail points (largest scores) where the closing point itself is dropped
  task automatic test_store_full();
    logic signed [COORD_W-1:0] rail;
    for (int i = 0; i < MAX_POINTS; i++)
      send_point(make_point($urandom, $urandom, $urandom, TAG_W'(i),
                            i == MAX_POINTS - 1), 1'b1);
    for (int i = 0; i < MAX_POINTS + 3; i++) begin
      rail = (i % 2 == 0) ? C_MAX : C_MIN;
      send_point(make_point(rail, rail, rail, TAG_W'(16'hF000 + i),
                            i == MAX_POINTS + 2), 1'b1);
    end
  endtask

  // whole sets with random content; mostly small, now and then large, the
  // last set trimmed to the item goal. repeats of earlier points give ties
  task automatic test_random_sets(input int item_goal, input bit gaps_allowed);
    point_t                    this_set [$];
    point_t                    p;
    logic signed [COORD_W-1:0] centre;
    int                        set_size;
    int                        sel;
    int                        items;
    bit                        set_gaps;
    items = 0;
    while (items < item_goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 85)      set_size = $urandom_range(1, 6);
      else if (sel < 98) set_size = $urandom_range(7, 40);
      else if (sel < 99) set_size = MAX_POINTS;
      else               set_size = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
      if (set_size > item_goal - items) set_size = item_goal - items;
      centre   = $urandom;
      set_gaps = gaps_allowed && $urandom_range(0, 1);
      this_set.delete();
      for (int i = 0; i < set_size; i++) begin
        if (this_set.size() != 0 && $urandom_range(0, 99) < 15) begin
          p = this_set[$urandom_range(0, this_set.size() - 1)];
        end else begin
          p = make_point(pick_coord(centre), pick_coord(centre), pick_coord(centre),
                         TAG_W'($urandom_range(0, 65535)), 1'b0);
        end
        p.point_tag  = TAG_W'($urandom_range(0, 65535));
        p.last_point = (i == set_size - 1);
        this_set.insert(this_set.size(), p);
        send_point(p, set_gaps);
        items++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking: done is a one-cycle strobe, sampled at the edge ending it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_winners.size() == 0) begin
        $display("%0t: unexpected result tag=%h score=%0d overflow=%b",
                 $time, result.best_tag, result.best_score, result.overflow);
        error_count++;
      end else begin
        want = pending_winners.pop_front();
        sets_checked++;
        if (result.best_tag !== want.best_tag) begin
          $display("%0t: best_tag expected %h actual %h",
                   $time, want.best_tag, result.best_tag);
          error_count++;
        end
        if (result.best_score !== want.best_score) begin
          $display("%0t: best_score expected %0d actual %0d",
                   $time, want.best_score, result.best_score);
          error_count++;
        end
        if (result.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b",
                   $time, want.overflow, result.overflow);
          error_count++;
        end
      end
    end
  end

  // watchdog: any run of cycles with no transaction on either side this long
  // means the block has hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lone_point();
    test_opposite_tie();
    test_coord_extremes();
    test_late_winner();
    test_duplicate_tie();
    test_store_full();
    test_random_sets(170, 1'b1);
    // closing stretch streams points with no idle cycles at all
    test_random_sets(50, 1'b0);

    start <= 1'b0;
    while (pending_winners.size() != 0) @(posedge clk);
    // give any stray strobe time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d points in %0d checked sets, %0d dropped on a full store",
             points_sent, sets_checked, points_dropped);
    $display("%0d mismatches found", error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: l1_medoid_select_top.f
rtl/l1ms_pkg.sv
rtl/l1ms_cell.sv
rtl/l1_medoid_select_top.sv
tb/tb_top.sv
